@@ rtl/sida_pkg.sv @@
`default_nettype none

package sida_pkg;

    localparam int BIN_W   = 32;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = 10;
    localparam int BCD_W   = DIG_W * NUM_DIG;
    localparam int CHAR_W  = 6;
    localparam int CNT_W   = $clog2(BIN_W);
    localparam int DCNT_W  = $clog2(NUM_DIG);

    localparam logic [CNT_W-1:0]  LAST_BIT   = CNT_W'(BIN_W - 1);
    localparam logic [DCNT_W-1:0] LAST_DIG   = DCNT_W'(NUM_DIG - 1);
    localparam logic [DIG_W-1:0]  ADJ_MIN    = 4'd5;
    localparam logic [DIG_W-1:0]  ADJ_ADD    = 4'd3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

endpackage

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Formats one signed 32-bit integer per input transaction as decimal ASCII text, most
// significant character first, one character per output transaction: an optional '-'
// followed by the digits with leading zeros suppressed (zero gives "0"); o_last_char
// marks the final character. The binary magnitude is converted to BCD by a bit-serial
// shift-and-add-3 unit, one input bit per cycle, and the digits are then loaded into the
// digit shift register. That register is walked one digit per cycle, skipped leading
// zeros included, after a '-' for a negative value; emitting a digit or a '-' waits while
// the output is stalled, skipping does not. o_stall is high from acceptance until the last
// character is registered, so a new transaction is not taken before the previous one's
// last character is registered.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [sida_pkg::BIN_W-1:0] i_value,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sida_pkg::CHAR_W-1:0]        o_char_code,
    output logic                               o_last_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic                             r_neg;
    logic                             r_skip;
    logic [sida_pkg::DCNT_W-1:0]      r_dcnt;
    logic [sida_pkg::BCD_W-1:0]       r_dig;
    logic                             r_o_valid;
    logic [sida_pkg::CHAR_W-1:0]      r_char;
    logic                             r_last;

    logic                             w_accept;
    logic [sida_pkg::BIN_W-1:0]       w_mag;
    logic                             w_done;
    logic [sida_pkg::BCD_W-1:0]       w_bcd;
    logic                             w_out_free;
    logic [sida_pkg::DIG_W-1:0]       w_top;
    logic                             w_skip;
    logic                             w_emit;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_mag      = i_value[sida_pkg::BIN_W-1] ? (sida_pkg::BIN_W'(0) - i_value) : i_value;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_top      = r_dig[sida_pkg::BCD_W-1 -: sida_pkg::DIG_W];
    assign w_skip     = r_skip && (w_top == '0) && (r_dcnt != sida_pkg::LAST_DIG);
    assign w_emit     = (r_state == S_EMIT) && w_out_free && (r_neg || !w_skip);

    sida_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_neg     <= 1'b0;
            r_skip    <= 1'b0;
            r_dcnt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_emit || (r_o_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= i_value[sida_pkg::BIN_W-1];
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_done) begin
                        r_dig   <= w_bcd;
                        r_dcnt  <= '0;
                        r_skip  <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_neg) begin
                        if (w_out_free) begin
                            r_char    <= sida_pkg::CHAR_MINUS;
                            r_last    <= 1'b0;
                            r_neg     <= 1'b0;
                        end
                    end else if (w_skip) begin
                        r_dig  <= {r_dig[sida_pkg::BCD_W-sida_pkg::DIG_W-1:0],
                                   {sida_pkg::DIG_W{1'b0}}};
                        r_dcnt <= r_dcnt + 1'b1;
                    end else if (w_out_free) begin
                        r_char    <= sida_pkg::CHAR_ZERO + {2'b00, w_top};
                        r_last    <= (r_dcnt == sida_pkg::LAST_DIG);
                        r_skip    <= 1'b0;
                        r_dig     <= {r_dig[sida_pkg::BCD_W-sida_pkg::DIG_W-1:0],
                                      {sida_pkg::DIG_W{1'b0}}};
                        r_dcnt    <= r_dcnt + 1'b1;
                        if (r_dcnt == sida_pkg::LAST_DIG) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

@@ rtl/sida_dabble.sv @@
`default_nettype none

module sida_dabble (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sida_pkg::BIN_W-1:0]  i_mag,
    output logic                             o_done,
    output logic [sida_pkg::BCD_W-1:0]       o_bcd
);

    logic                             r_busy;
    logic                             r_done;
    logic [sida_pkg::CNT_W-1:0]       r_cnt;
    logic [sida_pkg::BIN_W-1:0]       r_bin;
    logic [sida_pkg::BCD_W-1:0]       r_bcd;
    logic [sida_pkg::BCD_W-1:0]       w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < sida_pkg::NUM_DIG; d++) begin
            if (r_bcd[d*sida_pkg::DIG_W +: sida_pkg::DIG_W] >= sida_pkg::ADJ_MIN) begin
                w_adj[d*sida_pkg::DIG_W +: sida_pkg::DIG_W] =
                    r_bcd[d*sida_pkg::DIG_W +: sida_pkg::DIG_W] + sida_pkg::ADJ_ADD;
            end else begin
                w_adj[d*sida_pkg::DIG_W +: sida_pkg::DIG_W] =
                    r_bcd[d*sida_pkg::DIG_W +: sida_pkg::DIG_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_mag;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {w_adj[sida_pkg::BCD_W-2:0], r_bin[sida_pkg::BIN_W-1]};
                r_bin <= {r_bin[sida_pkg::BIN_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sida_pkg::LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

@@ rtl/sida_chk.sv @@
`default_nettype none

module sida_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [sida_pkg::CHAR_W-1:0] o_char_code,
    input wire logic                        o_last_char
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == sida_pkg::CHAR_MINUS) ||
                    ((o_char_code >= sida_pkg::CHAR_ZERO) &&
                     (o_char_code <= sida_pkg::CHAR_ZERO + 6'd9)))
        else $error("character code out of range");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == sida_pkg::CHAR_MINUS)) |-> !o_last_char)
        else $error("sign flagged as last character");

    // a sign that is taken is never followed by a second sign
    a_no_double_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && (o_char_code == sida_pkg::CHAR_MINUS)) |=>
            (!o_valid || (o_char_code != sida_pkg::CHAR_MINUS)))
        else $error("two signs in a row");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_char_code) && $stable(o_last_char)))
        else $error("stalled transaction changed");

endmodule

bind signed_int_to_decimal_ascii sida_chk u_sida_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_char_code (o_char_code),
    .o_last_char (o_last_char)
);

`default_nettype wire

@@ tb/decimal_text_checker.sv @@
`default_nettype none

module decimal_text_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire logic signed [sida_pkg::BIN_W-1:0] i_in_value,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire logic [sida_pkg::CHAR_W-1:0]       i_out_char,
    input  wire logic                              i_out_last,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sida_pkg::CHAR_W-1:0] code;
        logic                        last;
    } t_text_char;

    t_text_char pending_chars[$];
    int         fails = 0;

    // digits least significant first, then emitted most significant first
    function automatic void push_decimal_chars(input logic [sida_pkg::BIN_W-1:0] raw);
        logic [sida_pkg::BIN_W-1:0] mag;
        logic [sida_pkg::DIG_W-1:0] digits[sida_pkg::NUM_DIG];
        t_text_char                 ch;
        int                         n;
        int                         i;
        mag = raw[sida_pkg::BIN_W-1] ? (~raw + 1'b1) : raw;
        n = 0;
        do begin
            digits[n] = sida_pkg::DIG_W'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != 0 && n < sida_pkg::NUM_DIG);
        if (raw[sida_pkg::BIN_W-1]) begin
            ch.code = sida_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (i = n - 1; i >= 0; i--) begin
            ch.code = sida_pkg::CHAR_ZERO + sida_pkg::CHAR_W'(digits[i]);
            ch.last = (i == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            pending_chars.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_chars.size() == 0) begin
                    if (fails < 10) begin
                        $display("%0t: unexpected char %0d last %0b", $realtime, i_out_char,
                                 i_out_last);
                    end
                    fails++;
                end else begin
                    want = pending_chars.pop_front();
                    if (want.code !== i_out_char || want.last !== i_out_last) begin
                        if (fails < 10) begin
                            $display("%0t: char expected %0d last %0b, got %0d last %0b",
                                     $realtime, want.code, want.last, i_out_char, i_out_last);
                        end
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                push_decimal_chars(i_in_value);
            end
        end
        o_pending    <= pending_chars.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic signed [sida_pkg::BIN_W-1:0] i_value = '0;
    logic                              i_stall = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic [sida_pkg::CHAR_W-1:0]       o_char_code;
    logic                              o_last_char;

    int fail_count;
    int chars_pending;
    int idle_pct  = 0;
    int stall_pct = 0;

    int directed_values[] = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647,
                              -2147483647, 32'h8000_0000, 1000000000, -1000000000,
                              999999999, -999999999, 1234567890, -1234567890,
                              32'h5555_5555, 32'hAAAA_AAAA};
    int idle_pcts[4]  = '{0, 73, 0, 13};
    int stall_pcts[4] = '{0, 0, 73, 13};

    always #6 i_clk = ~i_clk;

    signed_int_to_decimal_ascii u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    decimal_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_value   (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_char   (o_char_code),
        .i_out_last   (o_last_char),
        .o_fail_count (fail_count),
        .o_pending    (chars_pending)
    );

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // mostly values of random length and sign, some full-width and extremes
    function automatic logic signed [sida_pkg::BIN_W-1:0] random_value();
        int unsigned lim;
        int unsigned mag;
        int          n;
        int          kind;
        kind = $urandom_range(9);
        if (kind < 3) begin
            return $urandom;
        end
        if (kind == 3) begin
            case ($urandom_range(4))
                0: return 0;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 1;
            endcase
        end
        n = $urandom_range(1, 9);
        lim = 1;
        repeat (n) lim = lim * 10;
        mag = $urandom % lim;
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // called at a clock edge, returns at the edge where the transaction is taken
    task automatic offer_value(input logic signed [sida_pkg::BIN_W-1:0] v);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_chars();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[k]) offer_value(directed_values[k]);
        drain_chars();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_pcts[p];
            stall_pct = stall_pcts[p];
            repeat (50) offer_value(random_value());
            if (p == 1) begin
                drain_chars();
            end
        end
        drain_chars();
        stall_pct = 0;
        repeat (60) @(posedge i_clk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
